// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the display scanner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on a given clock, off while the given active-low reset is low
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the block clock and reset
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/tdds_pkg.sv
// ----------------------------------------------------------------------------
// tdds_pkg
// Types and constants of the three digit display scanner.
// ----------------------------------------------------------------------------
package tdds_pkg;

  localparam int unsigned NUM_DIGITS_DEF  = 3;
  localparam int unsigned SETTLE_TIME_DEF = 10;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned MASK_W     = 3;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [TIME_W-1:0] SCAN_PERIOD_RST = 32'd2000;
  localparam logic [TIME_W-1:0] BLANK_TIME_RST  = 32'd50;
  localparam logic [SEG_W-1:0]  BLANK_PATTERN   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_PERIOD = 2'd0,
    REG_BLANK_TIME  = 2'd1,
    REG_SCAN_ENABLE = 2'd2,
    REG_SEG_INVERT  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SET  = 1'b1
  } req_type_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE      = 3'd0,
    PH_OFF       = 3'd1,
    PH_BLANK     = 3'd2,
    PH_SEND      = 3'd3,
    PH_SEND_WAIT = 3'd4,
    PH_TURN_ON   = 3'd5,
    PH_SHOW      = 3'd6
  } phase_e;

  typedef struct packed {
    logic [TIME_W-1:0] scan_period;
    logic [TIME_W-1:0] blank_time;
    logic              scan_enable;
    logic              seg_invert;
    logic              drv_clear;
  } cfg_t;

  typedef struct packed {
    req_type_e         req_type;
    logic              shifter_busy;
    logic [POS_W-1:0]  digit_position;
    logic [SEG_W-1:0]  segment_bits;
    logic              dp_on;
    logic              digit_enable;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  pos;
    logic [SEG_W-1:0]  seg;
    logic              dp;
    logic              ena;
  } dig_wr_t;

  typedef struct packed {
    logic [MASK_W-1:0]  digit_on_mask;
    logic               send_strobe;
    logic [SEG_W-1:0]   send_pattern;
    logic [PHASE_W-1:0] scan_phase;
  } result_t;

endpackage

// File: hdl/tdds_cfg.sv
// ----------------------------------------------------------------------------
// tdds_cfg
// Configuration registers of the display scanner.
// ----------------------------------------------------------------------------
module tdds_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tdds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tdds_pkg::TIME_W-1:0]          cfg_wdata_i,
  output tdds_pkg::cfg_t                       cfg_o
);
  import tdds_pkg::*;

  logic [TIME_W-1:0] scan_period_q;
  logic [TIME_W-1:0] blank_time_q;
  logic              scan_enable_q;
  logic              seg_invert_q;
  reg_idx_e          idx;

  assign idx = reg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_period_q <= SCAN_PERIOD_RST;
      blank_time_q  <= BLANK_TIME_RST;
      scan_enable_q <= 1'b1;
      seg_invert_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (idx)
        REG_SCAN_PERIOD: scan_period_q <= cfg_wdata_i;
        REG_BLANK_TIME:  blank_time_q  <= cfg_wdata_i;
        REG_SCAN_ENABLE: scan_enable_q <= cfg_wdata_i[0];
        REG_SEG_INVERT:  seg_invert_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.scan_period = scan_period_q;
    cfg_o.blank_time  = blank_time_q;
    cfg_o.scan_enable = scan_enable_q;
    cfg_o.seg_invert  = seg_invert_q;
    cfg_o.drv_clear   = cfg_we_i && (idx == REG_SCAN_ENABLE) && !cfg_wdata_i[0];
  end

endmodule

// File: hdl/tdds_digit_store.sv
// ----------------------------------------------------------------------------
// tdds_digit_store
// Per-digit segment, decimal point and enable registers; pattern build.
// ----------------------------------------------------------------------------
module tdds_digit_store #(
  parameter int unsigned NUM_DIGITS = 3,
  parameter int unsigned DIG_W      = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdds_pkg::dig_wr_t             wr_i,
  input  logic [DIG_W-1:0]              rd_idx_i,
  input  logic                          seg_invert_i,
  output logic [tdds_pkg::SEG_W-1:0]    pattern_o
);
  import tdds_pkg::*;

  logic [SEG_W-1:0] seg_q [NUM_DIGITS];
  logic             dp_q  [NUM_DIGITS];
  logic             ena_q [NUM_DIGITS];
  logic [SEG_W-1:0] raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        seg_q[i] <= '0;
        dp_q[i]  <= 1'b0;
        ena_q[i] <= 1'b1;
      end
    end else begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (wr_i.en && (32'(wr_i.pos) == 32'(i))) begin
          seg_q[i] <= wr_i.seg;
          dp_q[i]  <= wr_i.dp;
          ena_q[i] <= wr_i.ena;
        end
      end
    end
  end

  always_comb begin
    raw = BLANK_PATTERN;
    if (ena_q[rd_idx_i]) begin
      raw = seg_q[rd_idx_i] | SEG_W'(dp_q[rd_idx_i]);
    end
    pattern_o = seg_invert_i ? ~raw : raw;
  end

endmodule

// File: hdl/tdds_scan_fsm.sv
// ----------------------------------------------------------------------------
// tdds_scan_fsm
// Scan sequencer: time base, phase register, digit pointers and drivers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdds_scan_fsm #(
  parameter int unsigned NUM_DIGITS  = 3,
  parameter int unsigned SETTLE_TIME = 10,
  parameter int unsigned DIG_W       = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          busy_i,
  input  tdds_pkg::cfg_t                cfg_i,
  input  logic [tdds_pkg::SEG_W-1:0]    pattern_i,
  output logic [DIG_W-1:0]              coming_o,
  output tdds_pkg::result_t             res_o
);
  import tdds_pkg::*;

  phase_e                  phase_q, phase_d;
  logic [DIG_W-1:0]        shown_q, shown_d;
  logic [DIG_W-1:0]        coming_q, coming_d;
  logic [TIME_W-1:0]       now_q, now_d;
  logic [TIME_W-1:0]       last_sw_q, last_sw_d;
  logic [TIME_W-1:0]       last_ph_q, last_ph_d;
  logic [NUM_DIGITS-1:0]   drivers_q, drivers_d;

  logic                    step;
  logic                    strobe;
  logic                    elapsed;
  logic [TIME_W-1:0]       t_now;
  logic [TIME_W-1:0]       t_ref;
  logic [TIME_W-1:0]       t_lim;
  logic [NUM_DIGITS+MASK_W-1:0] drv_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      shown_q   <= '0;
      coming_q  <= '0;
      now_q     <= '0;
      last_sw_q <= '0;
      last_ph_q <= '0;
      drivers_q <= '0;
    end else begin
      phase_q   <= phase_d;
      shown_q   <= shown_d;
      coming_q  <= coming_d;
      now_q     <= now_d;
      last_sw_q <= last_sw_d;
      last_ph_q <= last_ph_d;
      drivers_q <= drivers_d;
    end
  end

  always_comb begin
    t_now = now_q + TIME_W'(1);
    step  = tick_i && cfg_i.scan_enable && !busy_i;

    t_ref = (phase_q == PH_IDLE) ? last_sw_q : last_ph_q;
    case (phase_q)
      PH_IDLE:  t_lim = cfg_i.scan_period;
      PH_BLANK: t_lim = cfg_i.blank_time;
      default:  t_lim = TIME_W'(SETTLE_TIME);
    endcase
    elapsed = (t_now - t_ref) >= t_lim;

    phase_d   = phase_q;
    shown_d   = shown_q;
    coming_d  = coming_q;
    now_d     = tick_i ? t_now : now_q;
    last_sw_d = last_sw_q;
    last_ph_d = last_ph_q;
    drivers_d = drivers_q;
    strobe    = 1'b0;

    if (step) begin
      case (phase_q)
        PH_IDLE: begin
          if (elapsed) begin
            phase_d   = PH_OFF;
            last_ph_d = t_now;
          end
        end
        PH_OFF: begin
          drivers_d = '0;
          phase_d   = PH_BLANK;
          last_ph_d = t_now;
        end
        PH_BLANK: begin
          if (elapsed) begin
            coming_d = (shown_q == DIG_W'(NUM_DIGITS - 1)) ? '0 : shown_q + DIG_W'(1);
            phase_d  = PH_SEND;
          end
        end
        PH_SEND: begin
          strobe    = 1'b1;
          phase_d   = PH_SEND_WAIT;
          last_ph_d = t_now;
        end
        PH_SEND_WAIT: begin
          if (elapsed) begin
            phase_d = PH_TURN_ON;
          end
        end
        PH_TURN_ON: begin
          drivers_d = drivers_q | (NUM_DIGITS'(1) << coming_q);
          shown_d   = coming_q;
          phase_d   = PH_SHOW;
          last_sw_d = t_now;
        end
        PH_SHOW: phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end

    if (cfg_i.drv_clear) begin
      drivers_d = '0;
    end

    drv_ext             = {MASK_W'(0), drivers_d};
    res_o.digit_on_mask = drv_ext[MASK_W-1:0];
    res_o.send_strobe   = strobe;
    res_o.send_pattern  = strobe ? pattern_i : BLANK_PATTERN;
    res_o.scan_phase    = phase_d;
  end

  assign coming_o = coming_q;

  `ASSERT_STD(a_one_driver, $onehot0(drivers_q), "more than one digit driver on")
  `ASSERT_STD(a_strobe_in_send, strobe |-> (phase_q == PH_SEND), "send outside send phase")
  `ASSERT_STD(a_turn_on_lights, (step && phase_q == PH_TURN_ON && !cfg_i.drv_clear) |=> (drivers_q != '0), "turn-on left all drivers off")

endmodule

// File: hdl/three_digit_display_scanner_top.sv
// ----------------------------------------------------------------------------
// three_digit_display_scanner_top
// Multiplexed seven-segment scanner with digit store and send sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tuser: request kind; tdata: busy, position, segments, dp, enable
//  m_axis    out        tdata: driver mask, strobe, pattern, phase
//  cfg       in         register index and write data, single-cycle write
//
//  One request per cycle while m_axis_tready does not hold the result; input register, then result register.
//  The phase update and one 32-bit subtract-compare sit between the two registers.
//  Reset loads the register defaults, phase idle, digits blank with enables set.
//  m_axis_tready low holds the result; one further request is then held at the input.
// ----------------------------------------------------------------------------
module three_digit_display_scanner_top #(
  parameter int unsigned NUM_DIGITS  = tdds_pkg::NUM_DIGITS_DEF,
  parameter int unsigned SETTLE_TIME = tdds_pkg::SETTLE_TIME_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] shifter_busy, [2:1] digit_position, [10:3] segment_bits,
  // [11] dp_on, [12] digit_enable
  input  logic [tdds_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] digit_on_mask, [3] send_strobe, [11:4] send_pattern, [14:12] scan_phase
  output logic [tdds_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tdds_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tdds_pkg::TIME_W-1:0]         cfg_wdata_i
);
  import tdds_pkg::*;

  localparam int unsigned DIG_W = $clog2(NUM_DIGITS);

  logic             in_vld_q;
  item_t            item_q;
  item_t            item_d;
  logic             res_vld_q;
  result_t          res_q;
  result_t          res;
  logic             advance;
  logic             accept;
  cfg_t             cfg;
  dig_wr_t          dig_wr;
  logic [DIG_W-1:0] coming;
  logic [SEG_W-1:0] pattern;

  assign advance       = in_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.req_type       = req_type_e'(s_axis_tuser);
    item_d.shifter_busy   = s_axis_tdata[0];
    item_d.digit_position = s_axis_tdata[2:1];
    item_d.segment_bits   = s_axis_tdata[10:3];
    item_d.dp_on          = s_axis_tdata[11];
    item_d.digit_enable   = s_axis_tdata[12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      res_vld_q <= advance || (res_vld_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  always_comb begin
    dig_wr.en  = advance && (item_q.req_type == REQ_SET);
    dig_wr.pos = item_q.digit_position;
    dig_wr.seg = item_q.segment_bits;
    dig_wr.dp  = item_q.dp_on;
    dig_wr.ena = item_q.digit_enable;
  end

  tdds_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tdds_digit_store #(
    .NUM_DIGITS (NUM_DIGITS),
    .DIG_W      (DIG_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (dig_wr),
    .rd_idx_i     (coming),
    .seg_invert_i (cfg.seg_invert),
    .pattern_o    (pattern)
  );

  tdds_scan_fsm #(
    .NUM_DIGITS  (NUM_DIGITS),
    .SETTLE_TIME (SETTLE_TIME),
    .DIG_W       (DIG_W)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (advance && (item_q.req_type == REQ_TICK)),
    .busy_i    (item_q.shifter_busy),
    .cfg_i     (cfg),
    .pattern_i (pattern),
    .coming_o  (coming),
    .res_o     (res)
  );

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {1'b0, res_q.scan_phase, res_q.send_pattern,
                          res_q.send_strobe, res_q.digit_on_mask};

endmodule
